FILE: sv/tpc_pkg.sv
// Shared types and constants of the triangle plane clipper.
// No dependencies; used by the clipper top level.
package tpc_pkg;

  localparam int FIELD_W     = 32;  // coordinate port width
  localparam int COLOR_W     = 24;
  localparam int NORM_W      = 18;  // plane normal component, Q1.16
  localparam int OFFSET_W    = 32;  // plane constant D
  localparam int NORMAL_FRAC = 16;  // fraction bits of the normal
  localparam int T_BITS      = 30;  // fraction bits of the edge parameter t
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORMAL_X,
    CFG_NORMAL_Y,
    CFG_NORMAL_Z,
    CFG_OFFSET
  } tpc_cfg_t;

  // How many vertices lie on the inside of the plane.
  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_ONE,
    MODE_TWO,
    MODE_ALL
  } tpc_mode_t;

endpackage

FILE: sv/tpc_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage, with payload.
// No package dependencies; instantiated by the clipper top level.
module tpc_div #(
  parameter int RW   = 38,
  parameter int QW   = 30,
  parameter int PAYW = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [1:0][RW-1:0]       in_rem,
  input  logic [1:0][RW-1:0]       in_den,
  input  logic [PAYW-1:0]          in_pay,
  output logic                     out_valid,
  output logic [1:0][QW-1:0]       out_q,
  output logic [PAYW-1:0]          out_pay
);

  logic [QW-1:0]                  v_r;
  logic [QW-1:0][1:0][RW-1:0]     rem_r, rem_nxt, src_rem;
  logic [QW-1:0][1:0][RW-1:0]     den_r, src_den;
  logic [QW-1:0][1:0][QW-1:0]     q_r, q_nxt, src_q;
  logic [QW-1:0][PAYW-1:0]        pay_r, src_pay;

  // stage g takes what stage g-1 holds; stage 0 takes the ports
  assign src_rem = {rem_r[QW-2:0], in_rem};
  assign src_den = {den_r[QW-2:0], in_den};
  assign src_q   = {q_r[QW-2:0], {(2*QW){1'b0}}};
  assign src_pay = {pay_r[QW-2:0], in_pay};

  always_comb begin
    logic [RW:0] sh;
    logic [RW:0] df;
    logic        ge;
    for (int g = 0; g < QW; g++) begin
      for (int j = 0; j < 2; j++) begin
        sh = {src_rem[g][j], 1'b0};
        df = sh - {1'b0, src_den[g][j]};
        ge = (sh >= {1'b0, src_den[g][j]});
        rem_nxt[g][j] = ge ? df[RW-1:0] : sh[RW-1:0];
        q_nxt[g][j]   = {src_q[g][j][QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      den_r <= src_den;
      q_r   <= q_nxt;
      pay_r <= src_pay;
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_q     = q_r[QW-1];
  assign out_pay   = pay_r[QW-1];

endmodule

FILE: sv/triangle_plane_clipper_top.sv
// Triangle clipper against one plane: top level with the full pipeline.
// Depends on tpc_pkg and tpc_div.
//
// Usage:
//  - Input channel: present a triangle on in_* and raise start; the transaction
//    is taken at a rising edge with start high and busy low.
//  - Configuration: cfg_we, cfg_index, cfg_wdata write the plane normal
//    (x, y, z, Q1.16) and offset D; write them only while the block is idle.
//  - Result channel: each result triangle shows on out_* for exactly one
//    cycle with out_valid high; out_last marks the final result of an input.
//    The receiver cannot stall, so there is no back-pressure from it.
//  - Path: the first result of a triangle passes, in order, the multiply,
//    distance sum, 30 divider stages, offset multiply, round and saturate,
//    and the output register.
//  - Throughput: one triangle per cycle while busy is low, when it yields
//    zero or one result; a split triangle's two results go out in turn,
//    since both share the single output register. busy is high while the
//    first goes into it, and every stage before the output register holds.
//  - Reset (rst_n, synchronous): drops every transaction in flight and
//    restores the plane z = 1.0 with D = -1.0.
module triangle_plane_clipper_top #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [tpc_pkg::FIELD_W-1:0]        in_v0_x,
  input  logic [tpc_pkg::FIELD_W-1:0]        in_v0_y,
  input  logic [tpc_pkg::FIELD_W-1:0]        in_v0_z,
  input  logic [tpc_pkg::FIELD_W-1:0]        in_v1_x,
  input  logic [tpc_pkg::FIELD_W-1:0]        in_v1_y,
  input  logic [tpc_pkg::FIELD_W-1:0]        in_v1_z,
  input  logic [tpc_pkg::FIELD_W-1:0]        in_v2_x,
  input  logic [tpc_pkg::FIELD_W-1:0]        in_v2_y,
  input  logic [tpc_pkg::FIELD_W-1:0]        in_v2_z,
  input  logic [tpc_pkg::COLOR_W-1:0]        in_color,
  input  logic                               cfg_we,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpc_pkg::OFFSET_W-1:0]       cfg_wdata,
  output logic                               out_valid,
  output logic [tpc_pkg::FIELD_W-1:0]        out_v0_x,
  output logic [tpc_pkg::FIELD_W-1:0]        out_v0_y,
  output logic [tpc_pkg::FIELD_W-1:0]        out_v0_z,
  output logic [tpc_pkg::FIELD_W-1:0]        out_v1_x,
  output logic [tpc_pkg::FIELD_W-1:0]        out_v1_y,
  output logic [tpc_pkg::FIELD_W-1:0]        out_v1_z,
  output logic [tpc_pkg::FIELD_W-1:0]        out_v2_x,
  output logic [tpc_pkg::FIELD_W-1:0]        out_v2_y,
  output logic [tpc_pkg::FIELD_W-1:0]        out_v2_z,
  output logic [tpc_pkg::COLOR_W-1:0]        out_color,
  output logic                               out_last
);

  // working coordinate width, product, sum, distance and divider widths
  localparam int CW  = (COORD_WIDTH < tpc_pkg::FIELD_W) ? COORD_WIDTH : tpc_pkg::FIELD_W;
  localparam int PW  = tpc_pkg::NORM_W + CW;
  localparam int SW  = PW + 2;
  localparam int DSH = SW - tpc_pkg::NORMAL_FRAC;
  localparam int DW  = ((DSH > tpc_pkg::OFFSET_W) ? DSH : tpc_pkg::OFFSET_W) + 1;
  localparam int RW  = DW + 1;
  localparam int QW  = tpc_pkg::T_BITS;
  localparam int OW  = CW + QW + 2;
  localparam int XW  = CW + 4;

  // Item payload that rides along the divider.
  typedef struct packed {
    logic [2:0][2:0][CW-1:0]       p;     // vertices
    logic [1:0][2:0][CW:0]         diff;  // b - a per intersection lane
    logic [tpc_pkg::COLOR_W-1:0]   color;
    tpc_pkg::tpc_mode_t            mode;
    logic [1:0]                    x;     // one inside: kept vertex; two: first inside
    logic [1:0]                    y;     // one inside: first cut slot; two: second inside
    logic [1:0]                    z;     // one inside: second cut slot
  } pay_t;

  localparam int PAYW = $bits(pay_t);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [tpc_pkg::NORM_W-1:0]   nx_r, ny_r, nz_r;
  logic signed [tpc_pkg::OFFSET_W-1:0] off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r  <= '0;
      ny_r  <= '0;
      nz_r  <= tpc_pkg::NORM_W'(1) << tpc_pkg::NORMAL_FRAC;
      off_r <= -(tpc_pkg::OFFSET_W'(1) << FRAC_BITS);
    end else if (cfg_we) begin
      case (tpc_pkg::tpc_cfg_t'(cfg_index))
        tpc_pkg::CFG_NORMAL_X: nx_r  <= cfg_wdata[tpc_pkg::NORM_W-1:0];
        tpc_pkg::CFG_NORMAL_Y: ny_r  <= cfg_wdata[tpc_pkg::NORM_W-1:0];
        tpc_pkg::CFG_NORMAL_Z: nz_r  <= cfg_wdata[tpc_pkg::NORM_W-1:0];
        tpc_pkg::CFG_OFFSET:   off_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline hold: a two-result triangle at the final stage freezes every stage
  // before the output register for one cycle while its first result goes out.
  // ---------------------------------------------------------------------------
  logic en;
  logic hold;
  logic phase_r;

  assign en   = !hold;
  assign busy = hold;

  // ---------------------------------------------------------------------------
  // Stage 1: normal times coordinate products
  // ---------------------------------------------------------------------------
  logic [2:0][2:0][CW-1:0]             pin;
  logic signed [tpc_pkg::NORM_W-1:0]   nrm [3];
  logic signed [PW-1:0]                prod_nxt [3][3];

  assign pin[0][0] = in_v0_x[CW-1:0];
  assign pin[0][1] = in_v0_y[CW-1:0];
  assign pin[0][2] = in_v0_z[CW-1:0];
  assign pin[1][0] = in_v1_x[CW-1:0];
  assign pin[1][1] = in_v1_y[CW-1:0];
  assign pin[1][2] = in_v1_z[CW-1:0];
  assign pin[2][0] = in_v2_x[CW-1:0];
  assign pin[2][1] = in_v2_y[CW-1:0];
  assign pin[2][2] = in_v2_z[CW-1:0];
  assign nrm[0]    = nx_r;
  assign nrm[1]    = ny_r;
  assign nrm[2]    = nz_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        prod_nxt[i][k] = nrm[k] * $signed(pin[i][k]);
      end
    end
  end

  logic                          v1_r;
  logic [2:0][2:0][CW-1:0]       p1_r;
  logic signed [PW-1:0]          prod1_r [3][3];
  logic [tpc_pkg::COLOR_W-1:0]   col1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r    <= pin;
      prod1_r <= prod_nxt;
      col1_r  <= in_color;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: signed distance d = floor(n.p / 2^16) + D, exact
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] dsum [3];
  logic signed [DW-1:0] d_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsum[i]  = SW'(prod1_r[i][0]) + SW'(prod1_r[i][1]) + SW'(prod1_r[i][2]);
      d_nxt[i] = DW'($signed(dsum[i][SW-1:tpc_pkg::NORMAL_FRAC])) + DW'(off_r);
    end
  end

  logic                          v2_r;
  logic [2:0][2:0][CW-1:0]       p2_r;
  logic signed [DW-1:0]          d2_r [3];
  logic [tpc_pkg::COLOR_W-1:0]   col2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_r   <= p1_r;
      d2_r   <= d_nxt;
      col2_r <= col1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Classification: pick the pair of edges to cut and set up the dividers.
  // A zero distance counts as inside.
  // ---------------------------------------------------------------------------
  logic [2:0]            ins;
  logic [1:0]            la [2];   // inside end of each cut edge
  logic [1:0]            lb [2];   // outside end of each cut edge
  pay_t                  pay3;
  logic [1:0][RW-1:0]    rem3, den3;

  assign ins = {~d2_r[2][DW-1], ~d2_r[1][DW-1], ~d2_r[0][DW-1]};

  always_comb begin
    pay3.p     = p2_r;
    pay3.color = col2_r;
    pay3.mode  = tpc_pkg::MODE_NONE;
    pay3.x     = 2'd0;
    pay3.y     = 2'd1;
    pay3.z     = 2'd2;
    la[0] = 2'd0;
    la[1] = 2'd0;
    lb[0] = 2'd1;
    lb[1] = 2'd2;
    case (ins)
      3'b111: pay3.mode = tpc_pkg::MODE_ALL;
      3'b001: begin
        pay3.mode = tpc_pkg::MODE_ONE;
        pay3.x = 2'd0; pay3.y = 2'd1; pay3.z = 2'd2;
      end
      3'b010: begin
        pay3.mode = tpc_pkg::MODE_ONE;
        pay3.x = 2'd1; pay3.y = 2'd0; pay3.z = 2'd2;
      end
      3'b100: begin
        pay3.mode = tpc_pkg::MODE_ONE;
        pay3.x = 2'd2; pay3.y = 2'd0; pay3.z = 2'd1;
      end
      3'b110: begin
        pay3.mode = tpc_pkg::MODE_TWO;
        pay3.x = 2'd1; pay3.y = 2'd2; pay3.z = 2'd0;
      end
      3'b101: begin
        pay3.mode = tpc_pkg::MODE_TWO;
        pay3.x = 2'd0; pay3.y = 2'd2; pay3.z = 2'd1;
      end
      3'b011: begin
        pay3.mode = tpc_pkg::MODE_TWO;
        pay3.x = 2'd0; pay3.y = 2'd1; pay3.z = 2'd2;
      end
      default: ;
    endcase
    // one inside: both cuts start at x, end at y and z
    // two inside: cuts run x to z and y to z (z is the outside vertex)
    if (pay3.mode == tpc_pkg::MODE_TWO) begin
      la[0] = pay3.x; lb[0] = pay3.z;
      la[1] = pay3.y; lb[1] = pay3.z;
    end else begin
      la[0] = pay3.x; lb[0] = pay3.y;
      la[1] = pay3.x; lb[1] = pay3.z;
    end
    for (int j = 0; j < 2; j++) begin
      rem3[j] = RW'(d2_r[la[j]]);
      den3[j] = RW'(d2_r[la[j]]) - RW'(d2_r[lb[j]]);
      for (int k = 0; k < 3; k++) begin
        pay3.diff[j][k] = (CW+1)'($signed(p2_r[lb[j]][k]))
                        - (CW+1)'($signed(p2_r[la[j]][k]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // t = floor(da * 2^30 / (da - db)), one bit per stage
  // ---------------------------------------------------------------------------
  logic                  dv_v;
  logic [1:0][QW-1:0]    dq;
  logic [PAYW-1:0]       dpay_bits;
  pay_t                  dpay;

  tpc_div #(
    .RW   (RW),
    .QW   (QW),
    .PAYW (PAYW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .in_rem    (rem3),
    .in_den    (den3),
    .in_pay    (pay3),
    .out_valid (dv_v),
    .out_q     (dq),
    .out_pay   (dpay_bits)
  );

  assign dpay = pay_t'(dpay_bits);

  // ---------------------------------------------------------------------------
  // Stage M: offset along the edge, (b - a) * t
  // ---------------------------------------------------------------------------
  logic signed [OW-1:0] off_nxt [2][3];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      for (int k = 0; k < 3; k++) begin
        off_nxt[j][k] = $signed(dpay.diff[j][k]) * $signed({1'b0, dq[j]});
      end
    end
  end

  logic                  vm_r;
  logic signed [OW-1:0]  offm_r [2][3];
  pay_t                  paym_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (en) begin
      vm_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      offm_r <= off_nxt;
      paym_r <= dpay;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage F: round half up, add the inside end, saturate to CW bits
  // ---------------------------------------------------------------------------
  localparam logic signed [OW:0] HALF = (OW+1)'(1) << (QW-1);

  logic [1:0]                 abase [2];
  logic signed [OW:0]         rsum;
  logic signed [XW-1:0]       xv;
  logic [1:0][2:0][CW-1:0]    isec_nxt;

  assign abase[0] = paym_r.x;
  assign abase[1] = (paym_r.mode == tpc_pkg::MODE_TWO) ? paym_r.y : paym_r.x;

  always_comb begin
    rsum = '0;
    xv   = '0;
    for (int j = 0; j < 2; j++) begin
      for (int k = 0; k < 3; k++) begin
        rsum = (OW+1)'(offm_r[j][k]) + HALF;
        xv   = XW'($signed(rsum[OW:QW])) + XW'($signed(paym_r.p[abase[j]][k]));
        if ((&xv[XW-1:CW-1]) | ~(|xv[XW-1:CW-1])) begin
          isec_nxt[j][k] = xv[CW-1:0];
        end else begin
          isec_nxt[j][k] = {xv[XW-1], {(CW-1){~xv[XW-1]}}};
        end
      end
    end
  end

  logic                       vf_r;
  logic [1:0][2:0][CW-1:0]    isec_r;
  pay_t                       payf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      isec_r <= isec_nxt;
      payf_r <= paym_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output: assemble result triangles; a split triangle's results go out in turn, in separate cycles
  // ---------------------------------------------------------------------------
  logic [2:0][2:0][CW-1:0]   res;
  logic                      res_last;

  assign hold = vf_r && (payf_r.mode == tpc_pkg::MODE_TWO) && !phase_r;

  always_comb begin
    res      = payf_r.p;
    res_last = 1'b1;
    case (payf_r.mode)
      tpc_pkg::MODE_ONE: begin
        res[payf_r.y] = isec_r[0];
        res[payf_r.z] = isec_r[1];
      end
      tpc_pkg::MODE_TWO: begin
        if (!phase_r) begin
          res[0]   = payf_r.p[payf_r.x];
          res[1]   = payf_r.p[payf_r.y];
          res[2]   = isec_r[0];
          res_last = 1'b0;
        end else begin
          res[0] = isec_r[0];
          res[1] = payf_r.p[payf_r.y];
          res[2] = isec_r[1];
        end
      end
      default: ;
    endcase
  end

  logic                          out_valid_r;
  logic                          out_last_r;
  logic [2:0][2:0][CW-1:0]       out_res_r;
  logic [tpc_pkg::COLOR_W-1:0]   out_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= vf_r && (payf_r.mode != tpc_pkg::MODE_NONE);
      phase_r     <= hold;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r   <= res;
    out_last_r  <= res_last;
    out_color_r <= payf_r.color;
  end

  assign out_valid = out_valid_r;
  assign out_last  = out_last_r;
  assign out_color = out_color_r;
  assign out_v0_x  = tpc_pkg::FIELD_W'($signed(out_res_r[0][0]));
  assign out_v0_y  = tpc_pkg::FIELD_W'($signed(out_res_r[0][1]));
  assign out_v0_z  = tpc_pkg::FIELD_W'($signed(out_res_r[0][2]));
  assign out_v1_x  = tpc_pkg::FIELD_W'($signed(out_res_r[1][0]));
  assign out_v1_y  = tpc_pkg::FIELD_W'($signed(out_res_r[1][1]));
  assign out_v1_z  = tpc_pkg::FIELD_W'($signed(out_res_r[1][2]));
  assign out_v2_x  = tpc_pkg::FIELD_W'($signed(out_res_r[2][0]));
  assign out_v2_y  = tpc_pkg::FIELD_W'($signed(out_res_r[2][1]));
  assign out_v2_z  = tpc_pkg::FIELD_W'($signed(out_res_r[2][2]));

endmodule

FILE: sv/tpc_chk.sv
// Port-level checker for the triangle plane clipper, bound to its top level.
// Depends only on the top level's port names.
module tpc_chk (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic out_last
);

  // busy lasts exactly one cycle per split triangle
  a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy) else $error("busy held for two cycles");

  // the first half of a split goes out right after busy
  a_split_first: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !out_last)) else $error("split first result missing");

  // the second half follows and closes the transaction
  a_split_second: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> ##1 (out_valid && out_last)) else $error("split second result missing");

  // reset empties the pipeline
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !busy)) else $error("activity right after reset");

endmodule

bind triangle_plane_clipper_top tpc_chk u_tpc_chk (.*);
